### src/sbgc_pkg.sv
`default_nettype none
package sbgc_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int SEQ_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int DEB_W          = 4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

    localparam logic [DEB_W-1:0]      DEBOUNCE_RST     = 4'd2;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 32'd700;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST = 32'd350;

    // gesture keys
    localparam logic [1:0] KEY_OK   = 2'd0;
    localparam logic [1:0] KEY_BACK = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;

    // event kinds within one gesture run
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_SHORT   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // gesture queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_PRESSED     = 2'd1,
        ST_WAIT_SECOND = 2'd2
    } t_gst;

    typedef struct packed {
        logic [1:0]       key;
        logic [SEQ_W-1:0] seq;
    } t_gesture;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage
`default_nettype wire

### src/sbgc_front.sv
`default_nettype none
module sbgc_front
    import sbgc_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic                  i_button_down,
    input  wire logic [TICK_WIDTH-1:0] i_now_tick,
    input  wire logic                  i_q_full,
    output      logic                  o_push,
    output      t_gesture              o_push_data
);

    localparam int CMP_W = (TICK_WIDTH > CFG_DATA_W) ? TICK_WIDTH : CFG_DATA_W;

    logic [DEB_W-1:0]      r_debounce;
    logic [CFG_DATA_W-1:0] r_long_ticks;
    logic [CFG_DATA_W-1:0] r_dbl_ticks;

    logic                  r_raw, n_raw;
    logic                  r_stable, n_stable;
    logic [DEB_W-1:0]      r_polls, n_polls;
    t_gst                  r_state, n_state;
    logic [TICK_WIDTH-1:0] r_press_time;
    logic [TICK_WIDTH-1:0] r_release_time;
    logic                  r_long_done;
    logic [SEQ_W-1:0]      r_count;

    logic                  accept;
    logic                  level_acc;
    logic [TICK_WIDTH-1:0] held;
    logic [TICK_WIDTH-1:0] since_rel;
    logic                  held_ge_long;
    logic                  window_out;
    logic                  emit;
    logic [1:0]            emit_key;
    logic                  set_press;
    logic                  set_release;
    logic                  set_long;
    logic                  clr_long;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_ticks <= LONG_PRESS_RST;
            r_dbl_ticks  <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:     r_debounce   <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS:   r_long_ticks <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_dbl_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // debounce
    always_comb begin
        n_raw   = r_raw;
        n_polls = r_polls;
        if (i_button_down == r_raw) begin
            if (r_polls < r_debounce) begin
                n_polls = r_polls + 1'b1;
            end
        end else begin
            n_raw   = i_button_down;
            n_polls = DEB_W'(1);
        end
        level_acc = (n_polls >= r_debounce) && (r_stable != n_raw);
        n_stable  = level_acc ? n_raw : r_stable;
    end

    assign held         = i_now_tick - r_press_time;
    assign since_rel    = i_now_tick - r_release_time;
    assign held_ge_long = CMP_W'(held) >= CMP_W'(r_long_ticks);
    assign window_out   = CMP_W'(since_rel) > CMP_W'(r_dbl_ticks);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (level_acc && n_stable) n_state = ST_PRESSED;
            end
            ST_PRESSED: begin
                if (!n_stable) n_state = held_ge_long ? ST_IDLE : ST_WAIT_SECOND;
            end
            ST_WAIT_SECOND: begin
                if ((level_acc && n_stable) || window_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // actions
    always_comb begin
        emit        = 1'b0;
        emit_key    = KEY_OK;
        set_press   = 1'b0;
        set_release = 1'b0;
        set_long    = 1'b0;
        clr_long    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (level_acc && n_stable) begin
                    set_press = 1'b1;
                    clr_long  = 1'b1;
                end
            end
            ST_PRESSED: begin
                if (n_stable) begin
                    if (!r_long_done && held_ge_long) begin
                        set_long = 1'b1;
                        emit     = 1'b1;
                        emit_key = KEY_OK;
                    end
                end else if (!held_ge_long) begin
                    set_release = 1'b1;
                end
            end
            ST_WAIT_SECOND: begin
                if (level_acc && n_stable) begin
                    emit     = 1'b1;
                    emit_key = KEY_BACK;
                    clr_long = 1'b1;
                end else if (window_out) begin
                    emit     = 1'b1;
                    emit_key = KEY_DOWN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= 1'b0;
            r_stable    <= 1'b0;
            r_polls     <= DEBOUNCE_RST;
            r_state     <= ST_IDLE;
            r_long_done <= 1'b0;
            r_count     <= '0;
        end else if (accept) begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_polls  <= n_polls;
            r_state  <= n_state;
            if (set_long) begin
                r_long_done <= 1'b1;
            end else if (clr_long) begin
                r_long_done <= 1'b0;
            end
            if (emit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && set_press) begin
            r_press_time <= i_now_tick;
        end
        if (accept && set_release) begin
            r_release_time <= i_now_tick;
        end
    end

    assign o_push          = accept && emit;
    assign o_push_data.key = emit_key;
    assign o_push_data.seq = r_count + 1'b1;

endmodule
`default_nettype wire

### src/sbgc_queue.sv
`default_nettype none
module sbgc_queue
    import sbgc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_gesture i_push_data,
    input  wire logic     i_pop,
    output      t_gesture o_head,
    output      t_qstat   o_qstat
);

    t_gesture          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/sbgc_back.sv
`default_nettype none
module sbgc_back
    import sbgc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_qstat           i_qstat,
    input  wire t_gesture         i_head,
    output      logic             o_pop,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      logic [1:0]       o_gesture_key,
    output      logic [1:0]       o_event_kind,
    output      logic [SEQ_W-1:0] o_sequence_res,
    output      logic             o_last_of_run
);

    logic             r_valid;
    logic [1:0]       r_kind;
    logic [1:0]       r_key;
    logic [SEQ_W-1:0] r_seq;

    logic out_free;
    logic run_done;

    // output slot frees when empty or when its item leaves this cycle
    assign out_free = !r_valid || !i_out_stall;
    assign run_done = !r_valid || (r_kind == EV_RELEASE);
    assign o_pop    = out_free && run_done && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= EV_PRESS;
        end else if (out_free) begin
            if (!run_done) begin
                r_kind <= (r_kind == EV_PRESS) ? EV_SHORT : EV_RELEASE;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_kind  <= EV_PRESS;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_key <= i_head.key;
            r_seq <= i_head.seq;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_gesture_key  = r_key;
    assign o_event_kind   = r_kind;
    assign o_sequence_res = r_seq;
    assign o_last_of_run  = (r_kind == EV_RELEASE);

endmodule
`default_nettype wire

### src/single_button_gesture_classifier.sv
`default_nettype none
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+---------------------------------------------
// poll in  | i_in_valid  | o_in_stall  | i_button_down, i_now_tick
// result   | o_out_valid | i_out_stall | o_gesture_key, o_event_kind, o_sequence_res,
//          |             |             | o_last_of_run
// config   | i_cfg_we    | (none)      | i_cfg_idx, i_cfg_data
//
// one poll is taken every cycle while the gesture queue is not full; its gesture, if
// any, enters the queue at the same edge; a gesture leaves as three result items on
// successive unstalled cycles; the first item of a gesture shows only once it has
// passed from the queue into the result register, which sits behind the queue
// reset is synchronous, active low; button starts released, no gesture pending
// o_in_stall rises only while the gesture queue is full, not while results wait
module single_button_gesture_classifier
    import sbgc_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // poll channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic                  i_button_down,
    input  wire logic [TICK_WIDTH-1:0] i_now_tick,
    // result channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [1:0]            o_gesture_key,
    output      logic [1:0]            o_event_kind,
    output      logic [SEQ_W-1:0]      o_sequence_res,
    output      logic                  o_last_of_run
);

    // front to queue
    logic     push;
    t_gesture push_data;
    // queue to back
    logic     pop;
    t_gesture head;
    t_qstat   qstat;

    // debounce, gesture state machine, config registers
    sbgc_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_button_down (i_button_down),
        .i_now_tick    (i_now_tick),
        .i_q_full      (qstat.full),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    // short gesture queue decouples polling from result delivery
    sbgc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_qstat     (qstat)
    );

    // expands each gesture into press, short, release items
    sbgc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (qstat),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_gesture_key  (o_gesture_key),
        .o_event_kind   (o_event_kind),
        .o_sequence_res (o_sequence_res),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
`default_nettype wire

### tb/sv/tb_single_button_gesture_classifier.sv
module tb_single_button_gesture_classifier;
    import sbgc_pkg::*;

    localparam int TW          = TICK_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    // index past the register list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result item as the block shows it
    typedef struct packed {
        logic [1:0]       key;
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } t_gesture_event;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_button_down;
    logic [TW-1:0]         i_now_tick;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_gesture_key;
    logic [1:0]            o_event_kind;
    logic [SEQ_W-1:0]      o_sequence_res;
    logic                  o_last_of_run;

    single_button_gesture_classifier #(
        .TICK_WIDTH(TW)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_button_down  (i_button_down),
        .i_now_tick     (i_now_tick),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_gesture_key  (o_gesture_key),
        .o_event_kind   (o_event_kind),
        .o_sequence_res (o_sequence_res),
        .o_last_of_run  (o_last_of_run)
    );

    // classifier copy kept by the bench: configuration
    logic [DEB_W-1:0] model_debounce;
    logic [TW-1:0]    model_long;
    logic [TW-1:0]    model_window;
    // classifier copy: debounce and gesture state
    logic             raw_lvl;
    logic             stable_lvl;
    logic [DEB_W-1:0] equal_polls;
    t_gst             press_state;
    logic [TW-1:0]    press_tick;
    logic [TW-1:0]    release_tick;
    logic             long_fired;
    logic [SEQ_W-1:0] gesture_seq;

    // result items still owed by the block, oldest first
    t_gesture_event gesture_events_due[$];

    int            mismatches  = 0;
    int            cycle_count = 0;
    int            polls_sent  = 0;
    logic [TW-1:0] tick_now    = '0;
    bit            in_gaps     = 1'b1;
    bit            out_stalls  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** single_button_gesture_classifier: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure: mostly free, short stalls, now and then a long one
    initial begin : out_stall_gen
        int r;
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (!out_stalls || r < 60) begin
                i_out_stall <= 1'b0;
            end else begin
                n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    task automatic compare_field(input string what, input logic [SEQ_W-1:0] want,
                                 input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // every accepted result item is held against the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_gesture_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gesture_events_due.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual key %0d kind %0d seq %0d last %0b"},
                         $time, o_gesture_key, o_event_kind, o_sequence_res, o_last_of_run);
                mismatches++;
            end else begin
                want = gesture_events_due.pop_front();
                compare_field("gesture_key", want.key, o_gesture_key);
                compare_field("event_kind", want.kind, o_event_kind);
                compare_field("sequence_res", want.seq, o_sequence_res);
                compare_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    task automatic reset_model();
        model_debounce = DEBOUNCE_RST;
        model_long     = LONG_PRESS_RST;
        model_window   = DOUBLE_CLICK_RST;
        raw_lvl        = 1'b0;
        stable_lvl     = 1'b0;
        equal_polls    = DEBOUNCE_RST;
        press_state    = ST_IDLE;
        press_tick     = '0;
        release_tick   = '0;
        long_fired     = 1'b0;
        gesture_seq    = '0;
    endtask

    // one gesture owes press, short and release items under one new number
    task automatic queue_gesture(input logic [1:0] key);
        gesture_seq = gesture_seq + 1'b1;
        gesture_events_due.push_back('{key, EV_PRESS, gesture_seq, 1'b0});
        gesture_events_due.push_back('{key, EV_SHORT, gesture_seq, 1'b0});
        gesture_events_due.push_back('{key, EV_RELEASE, gesture_seq, 1'b1});
    endtask

    // debounce one poll, then step the gesture machine
    task automatic classify_poll(input logic btn, input logic [TW-1:0] now);
        logic          accepted;
        logic [TW-1:0] held;
        if (btn == raw_lvl) begin
            if (equal_polls < model_debounce)
                equal_polls = equal_polls + 1'b1;
        end else begin
            raw_lvl     = btn;
            equal_polls = DEB_W'(1);
        end
        // a lowered debounce count sees a longer run as already settled
        accepted = (equal_polls >= model_debounce) && (stable_lvl != raw_lvl);
        if (accepted)
            stable_lvl = raw_lvl;

        case (press_state)
            ST_IDLE: begin
                if (accepted && stable_lvl) begin
                    press_state = ST_PRESSED;
                    press_tick  = now;
                    long_fired  = 1'b0;
                end
            end
            ST_PRESSED: begin
                held = now - press_tick;   // wraps with the tick counter
                if (stable_lvl) begin
                    if (!long_fired && held >= model_long) begin
                        long_fired = 1'b1;
                        queue_gesture(KEY_OK);
                    end
                end else if (held < model_long) begin
                    press_state  = ST_WAIT_SECOND;
                    release_tick = now;
                end else begin
                    // threshold passed: release adds no gesture, fired or not
                    press_state = ST_IDLE;
                end
            end
            ST_WAIT_SECOND: begin
                // a second press beats an expired window on the same poll
                if (accepted && stable_lvl) begin
                    queue_gesture(KEY_BACK);
                    press_state = ST_IDLE;
                    long_fired  = 1'b0;
                end else if ((now - release_tick) > model_window) begin
                    queue_gesture(KEY_DOWN);
                    press_state = ST_IDLE;
                end
            end
            default: press_state = ST_IDLE;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [TW-1:0] tick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        else if (r < 95)
            return $urandom_range(9, 60);
        else
            return $urandom;
    endfunction

    // send one poll item; valid stays up when the next item follows at once
    task automatic send_poll(input logic btn, input logic [TW-1:0] now);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_button_down <= btn;
        i_now_tick    <= now;
        do @(posedge i_clk); while (o_in_stall);
        classify_poll(btn, now);
        polls_sent++;
    endtask

    task automatic poll_at(input logic btn, input logic [TW-1:0] delta);
        tick_now = tick_now + delta;
        send_poll(btn, tick_now);
    endtask

    task automatic hold_level(input logic btn, input int n);
        repeat (n) poll_at(btn, tick_step());
    endtask

    // stop polling and let every owed item come out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (gesture_events_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:     model_debounce = data[DEB_W-1:0];
            CFG_LONG_PRESS:   model_long     = data;
            CFG_DOUBLE_CLICK: model_window   = data;
            default: ;
        endcase
    endtask

    // short press at reset settings: debounce 2, window runs out
    task automatic test_reset_defaults();
        poll_at(1'b1, 5);
        poll_at(1'b1, 5);
        poll_at(1'b0, 5);
        poll_at(1'b0, 5);
        poll_at(1'b0, 351);
    endtask

    task automatic test_long_press_edges();
        write_reg(CFG_DEBOUNCE, 1);
        write_reg(CFG_LONG_PRESS, 0);
        write_reg(CFG_DOUBLE_CLICK, 0);
        // zero threshold fires on the poll after the press
        poll_at(1'b1, 3);
        poll_at(1'b1, 0);
        poll_at(1'b0, 1);
        // threshold crossed on the releasing poll: silent
        write_reg(CFG_LONG_PRESS, 100);
        poll_at(1'b1, 1);
        poll_at(1'b0, 150);
        // largest threshold, reached exactly, then short release with zero window
        write_reg(CFG_LONG_PRESS, '1);
        poll_at(1'b1, 1);
        poll_at(1'b1, 32'hFFFF_FFFE);
        poll_at(1'b1, 1);
        poll_at(1'b0, 1);
        poll_at(1'b0, 1);
    endtask

    task automatic test_double_click_race();
        write_reg(CFG_LONG_PRESS, 100);
        write_reg(CFG_DOUBLE_CLICK, 50);
        // second press lands on the poll where the window has run out
        poll_at(1'b1, 1);
        poll_at(1'b0, 10);
        poll_at(1'b1, 60);
        poll_at(1'b0, 1);
        // largest window never runs out
        write_reg(CFG_DOUBLE_CLICK, '1);
        poll_at(1'b1, 1);
        poll_at(1'b0, 1);
        poll_at(1'b0, 32'hF000_0000);
        poll_at(1'b1, 1);
        poll_at(1'b0, 1);
    endtask

    task automatic test_tick_wrap();
        write_reg(CFG_DOUBLE_CLICK, 50);
        tick_now = 32'hFFFF_FFF0;
        poll_at(1'b1, 0);
        poll_at(1'b0, 32);
        poll_at(1'b0, 64);
    endtask

    task automatic test_debounce_edges();
        write_reg(CFG_UNUSED, $urandom);
        // zero count takes every change on its own poll
        write_reg(CFG_DEBOUNCE, 0);
        poll_at(1'b1, 1);
        poll_at(1'b0, 1);
        poll_at(1'b1, 1);
        poll_at(1'b0, 1);
        // run of five under count 15, then the count drops below the run
        write_reg(CFG_DEBOUNCE, 15);
        repeat (5) poll_at(1'b1, 1);
        write_reg(CFG_DEBOUNCE, {$urandom} << DEB_W | 3);
        poll_at(1'b1, 1);
        repeat (3) poll_at(1'b0, 1);
        poll_at(1'b0, 60);
    endtask

    // one press, maybe a second one, with some contact chatter before the first press
    task automatic play_gesture();
        int need;
        need = (model_debounce == 0) ? 1 : model_debounce;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                hold_level(1'b1, $urandom_range(1, need));
                hold_level(1'b0, 1);
            end
        end
        hold_level(1'b1, need + $urandom_range(0, 6));
        hold_level(1'b0, need + $urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) begin
            hold_level(1'b1, need + $urandom_range(0, 2));
            hold_level(1'b0, need + $urandom_range(0, 3));
        end
        hold_level(1'b0, $urandom_range(0, 4));
    endtask

    task automatic test_random_gestures();
        int r;
        int phase_end;
        for (int phase = 0; phase < 6; phase++) begin
            r = $urandom_range(0, 5);
            write_reg(CFG_DEBOUNCE, ($urandom << DEB_W) |
                      ((r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(1, 4)));
            r = $urandom_range(0, 99);
            write_reg(CFG_LONG_PRESS, (r < 10) ? 0 : (r < 18) ? '1 :
                      (r < 25) ? $urandom : $urandom_range(1, 80));
            r = $urandom_range(0, 99);
            write_reg(CFG_DOUBLE_CLICK, (r < 10) ? 0 : (r < 18) ? '1 :
                      (r < 25) ? $urandom : $urandom_range(1, 60));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, $urandom);
            // one phase runs flat out on both sides
            in_gaps    = (phase != 2) && ($urandom_range(0, 3) != 0);
            out_stalls = (phase != 2) && ($urandom_range(0, 3) != 0);
            tick_now   = $urandom;
            phase_end  = polls_sent + 45;
            while (polls_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 6)) poll_at(1'($urandom_range(0, 1)), tick_step());
                else
                    play_gesture();
            end
        end
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_DEBOUNCE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_button_down = 1'b0;
        i_now_tick    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reset_model();

        test_reset_defaults();
        test_long_press_edges();
        test_double_click_race();
        test_tick_wrap();
        test_debounce_edges();
        test_random_gestures();

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("** single_button_gesture_classifier: PASSED **");
        else
            $display("** single_button_gesture_classifier: FAILED **");
        $finish;
    end

endmodule

### filelist.f
src/sbgc_pkg.sv
src/sbgc_front.sv
src/sbgc_queue.sv
src/sbgc_back.sv
src/single_button_gesture_classifier.sv
tb/sv/tb_single_button_gesture_classifier.sv
